FILE: rtl/core/fub_pkg.sv
// ----------------------------------------------------------------------------
// fub_pkg
// Shared constants and controller/datapath interface types for the framed
// byte unstuff receiver.
// ----------------------------------------------------------------------------
package fub_pkg;

    // framing codes
    localparam logic [7:0] MARK_START = 8'd254;
    localparam logic [7:0] MARK_END   = 8'd255;
    localparam logic [7:0] MARK_ESC   = 8'd253;

    // header is source, destination, type, length
    localparam int unsigned HEADER_LEN = 4;
    localparam int unsigned HDR_POS_W  = 3;

    // payload buffer sizing
    localparam int unsigned MAX_PAYLOAD = 32;
    localparam int unsigned PAY_IDX_W   = $clog2(MAX_PAYLOAD);
    localparam int unsigned PAY_CNT_W   = $clog2(MAX_PAYLOAD + 1);

    // commands from controller to datapath
    typedef struct packed {
        logic take_byte;   // process the byte on the request channel
        logic idx_clear;   // restart the drain index
        logic idx_step;    // move to the next stored byte
        logic rd_en;       // read the buffer at the drain index
    } fub_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic release_msg; // current byte closes a frame addressed to us
        logic empty;       // no payload bytes stored
        logic last_item;   // drain index is at the final result
    } fub_sts_t;

endpackage

FILE: rtl/core/fub_datapath.sv
// ----------------------------------------------------------------------------
// fub_datapath
// Frame parser, unescape logic, payload buffer and result fields.
// ----------------------------------------------------------------------------
module fub_datapath (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  fub_pkg::fub_cmd_t            cmd,
    output fub_pkg::fub_sts_t            sts,
    input  logic [7:0]                   rx_byte,
    input  logic                         cfg_we,
    input  logic [7:0]                   cfg_own_address,
    output logic [7:0]                   source_address,
    output logic [7:0]                   message_type,
    output logic [7:0]                   data_byte,
    output logic                         data_valid,
    output logic [fub_pkg::PAY_CNT_W-1:0] payload_total,
    output logic                         overflow_flag,
    output logic                         last
);
    import fub_pkg::*;

    logic [7:0]           own_addr_reg, own_addr_next;
    logic                 in_frame_reg, in_frame_next;
    logic [HDR_POS_W-1:0] hdr_pos_reg, hdr_pos_next;
    logic                 esc_reg, esc_next;
    logic [7:0]           sender_reg, sender_next;
    logic [7:0]           target_reg, target_next;
    logic [7:0]           type_reg, type_next;
    logic [PAY_CNT_W-1:0] count_reg, count_next;
    logic                 dropped_reg, dropped_next;
    logic [PAY_IDX_W-1:0] idx_reg, idx_next;
    logic [7:0]           rd_data_reg;

    logic [7:0] payload_mem [MAX_PAYLOAD];

    logic       is_start;
    logic       is_end;
    logic       hdr_done;
    logic       pay_byte;
    logic [7:0] pay_value;
    logic       wr_en;

    // byte classification
    assign is_start  = (rx_byte == MARK_START);
    assign is_end    = (rx_byte == MARK_END);
    assign hdr_done  = (hdr_pos_reg == HDR_POS_W'(HEADER_LEN));
    assign pay_value = esc_reg ? (MARK_ESC + rx_byte) : rx_byte;
    assign pay_byte  = cmd.take_byte && in_frame_reg && !is_start && !is_end && hdr_done
                       && (esc_reg || (rx_byte != MARK_ESC));
    assign wr_en     = pay_byte && (count_reg < PAY_CNT_W'(MAX_PAYLOAD));

    // parser next state
    always_comb begin
        own_addr_next = cfg_we ? cfg_own_address : own_addr_reg;
        in_frame_next = in_frame_reg;
        hdr_pos_next  = hdr_pos_reg;
        esc_next      = esc_reg;
        sender_next   = sender_reg;
        target_next   = target_reg;
        type_next     = type_reg;
        count_next    = count_reg;
        dropped_next  = dropped_reg;
        if (cmd.take_byte) begin
            if (is_start) begin
                in_frame_next = 1'b1;
                hdr_pos_next  = '0;
                esc_next      = 1'b0;
                count_next    = '0;
                dropped_next  = 1'b0;
            end else if (in_frame_reg) begin
                if (is_end) begin
                    in_frame_next = 1'b0;
                    esc_next      = 1'b0;
                end else if (!hdr_done) begin
                    case (hdr_pos_reg)
                        HDR_POS_W'(0): sender_next = rx_byte;
                        HDR_POS_W'(1): target_next = rx_byte;
                        HDR_POS_W'(2): type_next   = rx_byte;
                        default:       ;
                    endcase
                    hdr_pos_next = hdr_pos_reg + HDR_POS_W'(1);
                end else if (esc_reg) begin
                    esc_next = 1'b0;
                end else if (rx_byte == MARK_ESC) begin
                    esc_next = 1'b1;
                end
                if (pay_byte) begin
                    if (wr_en) begin
                        count_next = count_reg + PAY_CNT_W'(1);
                    end else begin
                        dropped_next = 1'b1;
                    end
                end
            end
        end
    end

    // drain index
    always_comb begin
        idx_next = idx_reg;
        if (cmd.idx_clear) begin
            idx_next = '0;
        end else if (cmd.idx_step) begin
            idx_next = idx_reg + PAY_IDX_W'(1);
        end
    end

    // control and header registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_addr_reg <= '0;
            in_frame_reg <= 1'b0;
            hdr_pos_reg  <= '0;
            esc_reg      <= 1'b0;
            sender_reg   <= '0;
            target_reg   <= '0;
            type_reg     <= '0;
            count_reg    <= '0;
            dropped_reg  <= 1'b0;
            idx_reg      <= '0;
        end else begin
            own_addr_reg <= own_addr_next;
            in_frame_reg <= in_frame_next;
            hdr_pos_reg  <= hdr_pos_next;
            esc_reg      <= esc_next;
            sender_reg   <= sender_next;
            target_reg   <= target_next;
            type_reg     <= type_next;
            count_reg    <= count_next;
            dropped_reg  <= dropped_next;
            idx_reg      <= idx_next;
        end
    end

    // payload buffer, registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            payload_mem[count_reg[PAY_IDX_W-1:0]] <= pay_value;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= payload_mem[idx_reg];
        end
    end

    // status to controller
    assign sts.release_msg = in_frame_reg && is_end && hdr_done && (target_reg == own_addr_reg);
    assign sts.empty       = (count_reg == '0);
    assign sts.last_item   = (count_reg == '0)
                             || ((PAY_CNT_W'(idx_reg) + PAY_CNT_W'(1)) == count_reg);

    // result fields
    assign source_address = sender_reg;
    assign message_type   = type_reg;
    assign data_valid     = (count_reg != '0);
    assign data_byte      = data_valid ? rd_data_reg : 8'd0;
    assign payload_total  = count_reg;
    assign overflow_flag  = dropped_reg;
    assign last           = sts.last_item;

endmodule

FILE: rtl/core/fub_ctrl.sv
// ----------------------------------------------------------------------------
// fub_ctrl
// Controller: byte intake, then a drain of the stored payload as results.
// ----------------------------------------------------------------------------
module fub_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output fub_pkg::fub_cmd_t cmd,
    input  fub_pkg::fub_sts_t sts
);
    import fub_pkg::*;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_FETCH,
        ST_SHOW
    } state_t;

    state_t state_reg, state_next;
    logic   s_ready_reg, s_ready_next;
    logic   m_valid_reg, m_valid_next;

    // next state and commands
    always_comb begin
        state_next    = state_reg;
        s_ready_next  = s_ready_reg;
        m_valid_next  = m_valid_reg;
        cmd           = '0;
        case (state_reg)
            ST_RUN: begin
                cmd.take_byte = s_valid && s_ready_reg;
                if (cmd.take_byte && sts.release_msg) begin
                    cmd.idx_clear = 1'b1;
                    s_ready_next  = 1'b0;
                    if (sts.empty) begin
                        state_next   = ST_SHOW;
                        m_valid_next = 1'b1;
                    end else begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FETCH: begin
                cmd.rd_en    = 1'b1;
                state_next   = ST_SHOW;
                m_valid_next = 1'b1;
            end
            ST_SHOW: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    if (sts.last_item) begin
                        state_next   = ST_RUN;
                        s_ready_next = 1'b1;
                    end else begin
                        cmd.idx_step = 1'b1;
                        state_next   = ST_FETCH;
                    end
                end
            end
            default: begin
                state_next   = ST_RUN;
                s_ready_next = 1'b1;
                m_valid_next = 1'b0;
            end
        endcase
    end

    // state and registered handshake outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_RUN;
            s_ready_reg <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= s_ready_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = s_ready_reg;
    assign m_valid = m_valid_reg;

endmodule

FILE: rtl/core/framed_byte_unstuff_receiver.sv
// ----------------------------------------------------------------------------
// framed_byte_unstuff_receiver
// Start/end marker framed receiver with byte unescaping and address filter.
// ----------------------------------------------------------------------------
// Release: an end marker that releases a message moves the controller to a
//   buffer read state and then presents its first result; an empty message
//   needs no buffer read and presents its result directly.
// Throughput: 1 byte per cycle outside a drain; each result is a buffer read
//   then output, and the next read starts only once the output accepts the
//   result, so output stalls hold the drain, with no request accepted during it.
// Reset: synchronous active-low aresetn clears all control state and the
//   address register; the payload buffer is not cleared.
module framed_byte_unstuff_receiver (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_rx_byte,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [7:0]                    cfg_own_address,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [7:0]                    m_source_address,
    output logic [7:0]                    m_message_type,
    output logic [7:0]                    m_data_byte,
    output logic                          m_data_valid,
    output logic [fub_pkg::PAY_CNT_W-1:0] m_payload_total,
    output logic                          m_overflow_flag,
    output logic                          m_last
);
    import fub_pkg::*;

    fub_cmd_t cmd;
    fub_sts_t sts;

    // configuration is always taken
    assign cfg_ready = 1'b1;

    // controller
    fub_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    // datapath
    fub_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .rx_byte         (s_rx_byte),
        .cfg_we          (cfg_valid && cfg_ready),
        .cfg_own_address (cfg_own_address),
        .source_address  (m_source_address),
        .message_type    (m_message_type),
        .data_byte       (m_data_byte),
        .data_valid      (m_data_valid),
        .payload_total   (m_payload_total),
        .overflow_flag   (m_overflow_flag),
        .last            (m_last)
    );

endmodule

FILE: bench/framed_byte_unstuff_receiver_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// framed_byte_unstuff_receiver_test
// Feeds hand-built and random serial byte streams into the receiver under
// several node addresses. A scoreboard decodes the same stream, predicts
// every released message byte, and checks each result field by field.
// ----------------------------------------------------------------------------

// one released result as seen on the output channel
typedef struct packed {
    logic [7:0]                    source;
    logic [7:0]                    mtype;
    logic [7:0]                    data;
    logic                          data_ok;
    logic [fub_pkg::PAY_CNT_W-1:0] total;
    logic                          overflow;
    logic                          last;
} release_item_t;

// decodes accepted bytes and holds the results still owed by the block
class release_scoreboard;
    logic [7:0]    own_addr = 8'h00;
    bit            in_frame = 1'b0;
    int            hdr_pos = 0;
    bit            esc_pending = 1'b0;
    logic [7:0]    src_f = 8'h00;
    logic [7:0]    dst_f = 8'h00;
    logic [7:0]    type_f = 8'h00;
    logic [7:0]    pay_mem [fub_pkg::MAX_PAYLOAD];
    int            pay_cnt = 0;
    bit            dropped = 1'b0;
    release_item_t pending_results [$];
    int            n_errors = 0;
    int            n_requests = 0;
    int            n_messages = 0;
    int            n_overflowed = 0;
    int            n_results = 0;

    function void set_own_address(logic [7:0] value);
        own_addr = value;
    endfunction

    function void queue_item(logic [7:0] data, logic data_ok, logic last);
        release_item_t item;
        item.source   = src_f;
        item.mtype    = type_f;
        item.data     = data;
        item.data_ok  = data_ok;
        item.total    = pay_cnt[fub_pkg::PAY_CNT_W-1:0];
        item.overflow = dropped;
        item.last     = last;
        pending_results.push_back(item);
    endfunction

    function void store_payload(logic [7:0] value);
        if (pay_cnt < int'(fub_pkg::MAX_PAYLOAD)) begin
            pay_mem[pay_cnt] = value;
            pay_cnt++;
        end else begin
            dropped = 1'b1;
        end
    endfunction

    // one accepted request byte
    function void take_rx_byte(logic [7:0] b);
        logic [7:0] unescaped;
        n_requests++;
        // start marker opens or restarts a frame
        if (b == fub_pkg::MARK_START) begin
            in_frame    = 1'b1;
            hdr_pos     = 0;
            esc_pending = 1'b0;
            pay_cnt     = 0;
            dropped     = 1'b0;
            return;
        end
        if (!in_frame) return;
        // end marker: release only complete frames addressed to this node
        if (b == fub_pkg::MARK_END) begin
            in_frame    = 1'b0;
            esc_pending = 1'b0;
            if (hdr_pos < int'(fub_pkg::HEADER_LEN) || dst_f != own_addr) return;
            n_messages++;
            if (dropped) n_overflowed++;
            if (pay_cnt == 0) begin
                queue_item(8'h00, 1'b0, 1'b1);
            end else begin
                for (int i = 0; i < pay_cnt; i++) begin
                    queue_item(pay_mem[i], 1'b1, i == pay_cnt - 1);
                end
            end
            return;
        end
        // header: source, destination, type, unused length
        if (hdr_pos < int'(fub_pkg::HEADER_LEN)) begin
            if (hdr_pos == 0) src_f = b;
            else if (hdr_pos == 1) dst_f = b;
            else if (hdr_pos == 2) type_f = b;
            hdr_pos++;
            return;
        end
        // payload with escape removal, sum wraps at 8 bits
        if (esc_pending) begin
            esc_pending = 1'b0;
            unescaped = fub_pkg::MARK_ESC + b;
            store_payload(unescaped);
        end else if (b == fub_pkg::MARK_ESC) begin
            esc_pending = 1'b1;
        end else begin
            store_payload(b);
        end
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            n_errors++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    // one accepted result against the oldest expectation
    function void check_release(release_item_t got);
        release_item_t want;
        if (pending_results.size() == 0) begin
            n_errors++;
            $display("%0t: result with nothing pending: expected none, actual data %0d",
                     $time, got.data);
            return;
        end
        want = pending_results.pop_front();
        n_results++;
        compare_field("source_address", want.source, got.source);
        compare_field("message_type", want.mtype, got.mtype);
        compare_field("data_byte", want.data, got.data);
        compare_field("data_valid", want.data_ok, got.data_ok);
        compare_field("payload_total", want.total, got.total);
        compare_field("overflow_flag", want.overflow, got.overflow);
        compare_field("last", want.last, got.last);
    endfunction
endclass

module framed_byte_unstuff_receiver_test;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 250;
    localparam int DRAIN_PAUSE = 8;
    localparam int IDLE_PCT    = 37;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    logic [7:0]                    s_rx_byte;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [7:0]                    cfg_own_address;
    logic                          m_valid;
    logic                          m_ready;
    logic [7:0]                    m_source_address;
    logic [7:0]                    m_message_type;
    logic [7:0]                    m_data_byte;
    logic                          m_data_valid;
    logic [fub_pkg::PAY_CNT_W-1:0] m_payload_total;
    logic                          m_overflow_flag;
    logic                          m_last;

    release_scoreboard sb = new;
    release_item_t     seen_item;
    logic [7:0]        stim_q [$];
    bit                src_idle_en = 1'b1;
    bit                sink_idle_en = 1'b1;
    bit                hold_request = 1'b0;
    int                hold_left;
    int                cycle_count;
    int                n_settings = 0;

    framed_byte_unstuff_receiver dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_byte        (s_rx_byte),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_own_address  (cfg_own_address),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_source_address (m_source_address),
        .m_message_type   (m_message_type),
        .m_data_byte      (m_data_byte),
        .m_data_valid     (m_data_valid),
        .m_payload_total  (m_payload_total),
        .m_overflow_flag  (m_overflow_flag),
        .m_last           (m_last)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // run limit
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results still pending",
                 cycle_count, sb.pending_results.size());
        $display("RESULT: ERROR");
        $finish;
    end

    // result sink: random stalls plus an occasional long hold-off
    initial begin
        m_ready   = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= !sink_idle_en || ($urandom_range(99, 0) >= IDLE_PCT);
            end
        end
    end

    // handshake monitor on both channels
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                seen_item.source   = m_source_address;
                seen_item.mtype    = m_message_type;
                seen_item.data     = m_data_byte;
                seen_item.data_ok  = m_data_valid;
                seen_item.total    = m_payload_total;
                seen_item.overflow = m_overflow_flag;
                seen_item.last     = m_last;
                sb.check_release(seen_item);
            end
            if (s_valid && s_ready) sb.take_rx_byte(s_rx_byte);
        end
    end

    function automatic logic [7:0] rand_byte(int lo, int hi);
        return 8'($urandom_range(hi, lo));
    endfunction

    // well-formed frame; pay_len below zero picks a random length
    function automatic void push_frame(logic [7:0] own, bit force_match, int pay_len);
        int         n_pay;
        int         pick;
        logic [7:0] dst;
        dst = (force_match || $urandom_range(99, 0) < 75) ? own : rand_byte(0, 253);
        stim_q.push_back(fub_pkg::MARK_START);
        stim_q.push_back(rand_byte(0, 253));
        stim_q.push_back(dst);
        stim_q.push_back(rand_byte(0, 253));
        stim_q.push_back(rand_byte(0, 253));
        if (pay_len >= 0) begin
            n_pay = pay_len;
        end else begin
            pick = $urandom_range(99, 0);
            if (pick < 10) n_pay = 0;
            else if (pick < 85) n_pay = $urandom_range(8, 1);
            else if (pick < 95) n_pay = $urandom_range(31, 9);
            else n_pay = $urandom_range(36, 32);
        end
        // mostly plain bytes and escape pairs, some raw noise
        for (int i = 0; i < n_pay; i++) begin
            pick = $urandom_range(99, 0);
            if (pick < 60) begin
                stim_q.push_back(rand_byte(0, 252));
            end else if (pick < 92 || pay_len >= 0) begin
                stim_q.push_back(fub_pkg::MARK_ESC);
                stim_q.push_back(rand_byte(0, 253));
            end else begin
                stim_q.push_back(rand_byte(0, 255));
            end
        end
        // dangling escape now and then
        if ($urandom_range(99, 0) < 10) stim_q.push_back(fub_pkg::MARK_ESC);
        stim_q.push_back(fub_pkg::MARK_END);
    endfunction

    // random mix of good frames, broken frames and line noise
    function automatic void push_random_bytes(logic [7:0] own, int n_bytes);
        int kind;
        int goal;
        goal = stim_q.size() + n_bytes;
        while (stim_q.size() < goal) begin
            kind = $urandom_range(99, 0);
            if (kind < 70) begin
                push_frame(own, 1'b0, -1);
            end else if (kind < 80) begin
                // noise between frames, maybe a stray end marker
                repeat ($urandom_range(4, 1)) stim_q.push_back(rand_byte(0, 253));
                if ($urandom_range(1, 0) == 1) stim_q.push_back(fub_pkg::MARK_END);
            end else if (kind < 90) begin
                // frame cut short inside the header
                stim_q.push_back(fub_pkg::MARK_START);
                repeat ($urandom_range(3, 0)) stim_q.push_back(rand_byte(0, 253));
                stim_q.push_back(fub_pkg::MARK_END);
            end else begin
                // partial frame abandoned by a new start marker
                stim_q.push_back(fub_pkg::MARK_START);
                repeat ($urandom_range(7, 1)) stim_q.push_back(rand_byte(0, 253));
                push_frame(own, 1'b0, -1);
            end
        end
    endfunction

    // hand-built cases, run with own address 0
    function automatic void push_directed();
        // noise outside any frame, then a stray end marker
        stim_q.push_back(8'h00); stim_q.push_back(fub_pkg::MARK_ESC);
        stim_q.push_back(8'h7F); stim_q.push_back(fub_pkg::MARK_END);
        // frames that end before the header is complete
        stim_q.push_back(fub_pkg::MARK_START); stim_q.push_back(fub_pkg::MARK_END);
        stim_q.push_back(fub_pkg::MARK_START); stim_q.push_back(8'h11);
        stim_q.push_back(8'h00); stim_q.push_back(8'h22);
        stim_q.push_back(fub_pkg::MARK_END);
        // empty payload addressed here
        stim_q.push_back(fub_pkg::MARK_START); stim_q.push_back(8'hAA);
        stim_q.push_back(8'h00); stim_q.push_back(8'h5A);
        stim_q.push_back(8'hFD); stim_q.push_back(fub_pkg::MARK_END);
        // payload extremes, escape wrap-around, dangling escape at the end
        stim_q.push_back(fub_pkg::MARK_START); stim_q.push_back(8'h00);
        stim_q.push_back(8'h00); stim_q.push_back(8'hFD);
        stim_q.push_back(8'hFD); stim_q.push_back(8'h00);
        stim_q.push_back(8'hFC);
        stim_q.push_back(fub_pkg::MARK_ESC); stim_q.push_back(8'h00);
        stim_q.push_back(fub_pkg::MARK_ESC); stim_q.push_back(8'h01);
        stim_q.push_back(fub_pkg::MARK_ESC); stim_q.push_back(8'h02);
        stim_q.push_back(fub_pkg::MARK_ESC); stim_q.push_back(fub_pkg::MARK_ESC);
        stim_q.push_back(fub_pkg::MARK_ESC); stim_q.push_back(fub_pkg::MARK_END);
        // frame for another node is dropped
        stim_q.push_back(fub_pkg::MARK_START); stim_q.push_back(8'h01);
        stim_q.push_back(8'h05); stim_q.push_back(8'h02);
        stim_q.push_back(8'h00); stim_q.push_back(8'h09);
        stim_q.push_back(fub_pkg::MARK_END);
        // start marker in mid-frame restarts it and clears the escape
        stim_q.push_back(fub_pkg::MARK_START); stim_q.push_back(8'h01);
        stim_q.push_back(8'h00); stim_q.push_back(8'h02);
        stim_q.push_back(8'h00); stim_q.push_back(8'h07);
        stim_q.push_back(fub_pkg::MARK_ESC);
        stim_q.push_back(fub_pkg::MARK_START); stim_q.push_back(8'hFD);
        stim_q.push_back(8'h00); stim_q.push_back(8'h00);
        stim_q.push_back(8'h00); stim_q.push_back(8'h08);
        stim_q.push_back(fub_pkg::MARK_END);
        // payload past capacity: extra bytes dropped, overflow flagged
        stim_q.push_back(fub_pkg::MARK_START); stim_q.push_back(8'h09);
        stim_q.push_back(8'h00); stim_q.push_back(8'h33);
        stim_q.push_back(8'h00);
        for (int i = 0; i < 35; i++) stim_q.push_back(8'((i * 7) % 253));
        stim_q.push_back(fub_pkg::MARK_END);
    endfunction

    // send every queued byte as one request each
    task automatic send_stream();
        foreach (stim_q[i]) begin
            while (src_idle_en && $urandom_range(99, 0) < IDLE_PCT) begin
                @(negedge aclk);
                s_valid <= 1'b0;
            end
            @(negedge aclk);
            s_valid   <= 1'b1;
            s_rx_byte <= stim_q[i];
            do @(posedge aclk); while (!s_ready);
        end
        @(negedge aclk);
        s_valid <= 1'b0;
        stim_q.delete();
    endtask

    // wait for all owed results, then let the last byte settle
    task automatic wait_drained();
        while (sb.pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_PAUSE) @(posedge aclk);
    endtask

    task automatic write_own_address(input logic [7:0] value);
        @(negedge aclk);
        cfg_valid       <= 1'b1;
        cfg_own_address <= value;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_own_address(value);
        n_settings++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [7:0] own, input int n_bytes,
                             input bit quiet, input bit hold_off);
        write_own_address(own);
        src_idle_en  = !quiet;
        sink_idle_en = !quiet;
        // a long message up front so the hold-off backs up the input
        if (hold_off) begin
            push_frame(own, 1'b1, 12);
            hold_request = 1'b1;
        end
        push_random_bytes(own, n_bytes);
        send_stream();
        wait_drained();
    endtask

    // main sequence
    initial begin
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_rx_byte       = 8'h00;
        cfg_valid       = 1'b0;
        cfg_own_address = 8'h00;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        write_own_address(8'h00);
        push_directed();
        send_stream();
        wait_drained();

        // all-ones address: a header byte of 255 closes the frame, so nothing matches
        run_phase(8'hFF, 10, 1'b0, 1'b0);
        run_phase(8'hFD, 35, 1'b0, 1'b0);
        run_phase(rand_byte(0, 253), 40, 1'b0, 1'b1);
        run_phase(8'h01, 35, 1'b1, 1'b0);
        run_phase(rand_byte(0, 253), 30, 1'b0, 1'b0);

        $display("stream of %0d request bytes under %0d address settings",
                 sb.n_requests, n_settings);
        $display("%0d messages released (%0d with overflow), %0d results checked",
                 sb.n_messages, sb.n_overflowed, sb.n_results);
        if (sb.n_errors == 0 && sb.pending_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
